>>> src/sthb_pkg.sv
// Shared types, constants and control store for the tare/hold/BMI scale block.
`default_nettype none
package sthb_pkg;

    localparam int unsigned HEIGHT_W = 12;
    localparam int unsigned RAW_W    = 19;
    localparam int unsigned NET_W    = 18;
    localparam int unsigned BMI_W    = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned MS_W     = 16;
    localparam int unsigned PROD_W   = 35;
    localparam int unsigned HSQ_W    = 24;
    localparam int unsigned STEP_W   = 3;
    localparam int unsigned CNT_W    = 5;
    localparam int unsigned IN_W     = 72;
    localparam int unsigned OUT_W    = 72;

    localparam logic [16:0]     BMI_SCALE     = 17'd100000;
    localparam logic [MS_W-1:0] TARE_MS_RESET = 16'd1000;
    localparam logic [CNT_W-1:0] DIV_STEPS    = 5'd16;

    // datapath operation selected by the control word
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_NET,
        OP_MUL,
        OP_PREP,
        OP_DIV,
        OP_COMMIT
    } op_t;

    // jump condition: jump to target when true, else fall through
    typedef enum logic [2:0] {
        C_NONE,
        C_NO_INPUT,
        C_DIV_SKIP,
        C_DIV_MORE,
        C_OUT_BUSY,
        C_ALWAYS
    } cond_t;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic div_skip;
        logic div_last;
        logic out_free;
    } flags_t;

    localparam logic [STEP_W-1:0] ST_LOAD   = 3'd0;
    localparam logic [STEP_W-1:0] ST_NET    = 3'd1;
    localparam logic [STEP_W-1:0] ST_MUL    = 3'd2;
    localparam logic [STEP_W-1:0] ST_PREP   = 3'd3;
    localparam logic [STEP_W-1:0] ST_DIV    = 3'd4;
    localparam logic [STEP_W-1:0] ST_COMMIT = 3'd5;
    localparam logic [STEP_W-1:0] ST_RET    = 3'd6;

    function automatic ctrl_t rom_word(input logic [STEP_W-1:0] step);
        ctrl_t w;
        begin
            case (step)
                ST_LOAD:   w = '{op: OP_LOAD,   cond: C_NO_INPUT, target: ST_LOAD};
                ST_NET:    w = '{op: OP_NET,    cond: C_NONE,     target: ST_LOAD};
                ST_MUL:    w = '{op: OP_MUL,    cond: C_NONE,     target: ST_LOAD};
                ST_PREP:   w = '{op: OP_PREP,   cond: C_DIV_SKIP, target: ST_COMMIT};
                ST_DIV:    w = '{op: OP_DIV,    cond: C_DIV_MORE, target: ST_DIV};
                ST_COMMIT: w = '{op: OP_COMMIT, cond: C_OUT_BUSY, target: ST_COMMIT};
                ST_RET:    w = '{op: OP_NOP,    cond: C_ALWAYS,   target: ST_LOAD};
                default:   w = '{op: OP_NOP,    cond: C_ALWAYS,   target: ST_LOAD};
            endcase
            return w;
        end
    endfunction

endpackage
`default_nettype wire

>>> src/sthb_seq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
`default_nettype none
module sthb_seq
    import sthb_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire flags_t flags,
    output ctrl_t       ctrl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              take_jump;

    assign ctrl = rom_word(step_reg);

    always_comb
    begin
        case (ctrl.cond)
            C_NONE:     take_jump = 1'b0;
            C_NO_INPUT: take_jump = !flags.in_valid;
            C_DIV_SKIP: take_jump = flags.div_skip;
            C_DIV_MORE: take_jump = !flags.div_last;
            C_OUT_BUSY: take_jump = !flags.out_free;
            C_ALWAYS:   take_jump = 1'b1;
            default:    take_jump = 1'b1;
        endcase
        step_next = take_jump ? ctrl.target : step_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_LOAD;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule
`default_nettype wire

>>> src/scale_tare_hold_bmi.sv
// Top level: tare, hold and BMI weighing indicator with a microcoded datapath.
`default_nettype none
// One input word is one sample tick; one output word comes back per tick. The block works on
// one word at a time: it takes the next word only after the current one is committed. A
// restoring divider forms net weight*100000/height^2 in 16 iterations, skipped when the
// height is zero or the BMI saturates. A finished word waits in the output register while
// the next input is taken; if the previous word is still waiting there at the commit step,
// the block stalls until it is taken. The tare display time (tare_ms_reg) resets to 1000;
// the user must write it through cfg_we/cfg_wdata only while the block is idle, which the block does not enforce.
module scale_tare_hold_bmi
    import sthb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // height_mm[11:0], weight_g[30:12], hold_pin[31], reset_pin[32], tare_pin[33],
    // now_ms[65:34], zero pad[71:66]
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // shown_height_mm[11:0], shown_weight_g[29:12], shown_bmi_centi[45:30],
    // hold_active[46], tare_indicator[47], tare_offset_out_g[66:48], zero pad[71:67]
    output logic [OUT_W-1:0]      m_axis_tdata,
    input  wire logic             cfg_we,
    input  wire logic [MS_W-1:0]  cfg_wdata
);

    ctrl_t  ctrl;
    flags_t flags;

    // captured input word
    logic [HEIGHT_W-1:0] h_reg;
    logic [RAW_W-1:0]    raw_reg;
    logic                hold_pin_reg;
    logic                reset_pin_reg;
    logic                tare_pin_reg;
    logic [TIME_W-1:0]   now_reg;

    // model state
    logic [MS_W-1:0]     tare_ms_reg;
    logic                prev_hold_reg, prev_hold_next;
    logic                prev_reset_reg, prev_reset_next;
    logic                prev_tare_reg, prev_tare_next;
    logic [RAW_W-1:0]    offset_reg, offset_next;
    logic                tare_flag_reg, tare_flag_next;
    logic [TIME_W-1:0]   tare_start_reg, tare_start_next;
    logic                hold_flag_reg, hold_flag_next;
    logic [HEIGHT_W-1:0] held_h_reg, held_h_next;
    logic [NET_W-1:0]    held_w_reg, held_w_next;
    logic [BMI_W-1:0]    held_b_reg, held_b_next;

    // arithmetic
    logic [NET_W-1:0]    net_reg, net_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [HSQ_W-1:0]    hsq_reg, hsq_next;
    logic [HSQ_W-1:0]    rem_reg, rem_next;
    logic [BMI_W-1:0]    q_reg, q_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    out_data_reg, out_data_next;

    logic                in_fire;
    logic                commit_fire;
    logic                tare_edge;
    logic                flag_tmp;
    logic [RAW_W-1:0]    off_tmp;
    logic [TIME_W-1:0]   start_tmp;
    logic [TIME_W-1:0]   elapsed;
    logic [RAW_W:0]      diff;
    logic [HSQ_W-(PROD_W-BMI_W)-1:0] prod_hi_pad;
    logic [HSQ_W:0]      trial;
    logic                trial_ge;
    logic                ovf;
    logic                hold_edge;
    logic                reset_edge;
    logic [HEIGHT_W-1:0] sh;
    logic [NET_W-1:0]    sw;
    logic [BMI_W-1:0]    sb;

    sthb_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    assign s_axis_tready = (ctrl.op == OP_LOAD);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign flags.in_valid = s_axis_tvalid;
    assign flags.out_free = !out_valid_reg || m_axis_tready;
    assign flags.div_last = (cnt_reg == 5'd1);
    // quotient would not fit 16 bits when prod>>16 >= height^2
    assign prod_hi_pad    = '0;
    assign ovf            = {5'd0, prod_reg[PROD_W-1:BMI_W]} >= hsq_reg;
    assign flags.div_skip = (h_reg == '0) || ovf;

    assign commit_fire = (ctrl.op == OP_COMMIT) && flags.out_free;

    // tare edge, timeout and net weight
    assign tare_edge = prev_tare_reg && !tare_pin_reg;
    assign off_tmp   = tare_edge ? raw_reg : offset_reg;
    assign flag_tmp  = tare_edge || tare_flag_reg;
    assign start_tmp = tare_edge ? now_reg : tare_start_reg;
    assign elapsed   = now_reg - start_tmp;
    assign diff      = {raw_reg[RAW_W-1], raw_reg} - {off_tmp[RAW_W-1], off_tmp};

    // one restoring division step
    assign trial    = {rem_reg, q_reg[BMI_W-1]};
    assign trial_ge = trial >= {1'b0, hsq_reg};

    assign hold_edge  = prev_hold_reg && !hold_pin_reg && !hold_flag_reg;
    assign reset_edge = prev_reset_reg && !reset_pin_reg;

    always_comb
    begin
        offset_next     = offset_reg;
        tare_flag_next  = tare_flag_reg;
        tare_start_next = tare_start_reg;
        net_next        = net_reg;
        prod_next       = prod_reg;
        hsq_next        = hsq_reg;
        rem_next        = rem_reg;
        q_next          = q_reg;
        cnt_next        = cnt_reg;
        case (ctrl.op)
            OP_NET:
            begin
                offset_next     = off_tmp;
                tare_start_next = start_tmp;
                tare_flag_next  = flag_tmp && (elapsed < {16'd0, tare_ms_reg});
                if (diff[RAW_W])
                    net_next = '0;
                else if (diff[RAW_W-1])
                    net_next = '1;
                else
                    net_next = diff[NET_W-1:0];
            end
            OP_MUL:
            begin
                prod_next = {17'd0, net_reg} * {18'd0, BMI_SCALE};
                hsq_next  = {12'd0, h_reg} * {12'd0, h_reg};
            end
            OP_PREP:
            begin
                cnt_next = DIV_STEPS;
                rem_next = {prod_hi_pad, prod_reg[PROD_W-1:BMI_W]};
                if (h_reg == '0)
                    q_next = '0;
                else if (ovf)
                    q_next = '1;
                else
                    q_next = prod_reg[BMI_W-1:0];
            end
            OP_DIV:
            begin
                rem_next = trial_ge ? HSQ_W'(trial - {1'b0, hsq_reg}) : trial[HSQ_W-1:0];
                q_next   = {q_reg[BMI_W-2:0], trial_ge};
                cnt_next = cnt_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // hold latch, reset clear, button levels and the result word
    always_comb
    begin
        prev_hold_next  = prev_hold_reg;
        prev_reset_next = prev_reset_reg;
        prev_tare_next  = prev_tare_reg;
        hold_flag_next  = hold_flag_reg;
        held_h_next     = held_h_reg;
        held_w_next     = held_w_reg;
        held_b_next     = held_b_reg;
        if (commit_fire)
        begin
            prev_hold_next  = hold_pin_reg;
            prev_reset_next = reset_pin_reg;
            prev_tare_next  = tare_pin_reg;
            if (reset_edge)
            begin
                hold_flag_next = 1'b0;
                held_h_next    = '0;
                held_w_next    = '0;
                held_b_next    = '0;
            end
            else if (hold_edge)
            begin
                hold_flag_next = 1'b1;
                held_h_next    = h_reg;
                held_w_next    = net_reg;
                held_b_next    = q_reg;
            end
        end

        if (hold_flag_next)
        begin
            sh = held_h_next;
            sw = held_w_next;
            sb = held_b_next;
        end
        else
        begin
            sh = h_reg;
            sw = net_reg;
            sb = q_reg;
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (commit_fire)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {5'd0, offset_reg, tare_flag_reg, hold_flag_next, sb, sw, sh};
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // captured word and working registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            h_reg         <= s_axis_tdata[11:0];
            raw_reg       <= s_axis_tdata[30:12];
            hold_pin_reg  <= s_axis_tdata[31];
            reset_pin_reg <= s_axis_tdata[32];
            tare_pin_reg  <= s_axis_tdata[33];
            now_reg       <= s_axis_tdata[65:34];
        end
        net_reg      <= net_next;
        prod_reg     <= prod_next;
        hsq_reg      <= hsq_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tare_ms_reg    <= TARE_MS_RESET;
            prev_hold_reg  <= 1'b1;
            prev_reset_reg <= 1'b1;
            prev_tare_reg  <= 1'b1;
            offset_reg     <= '0;
            tare_flag_reg  <= 1'b0;
            tare_start_reg <= '0;
            hold_flag_reg  <= 1'b0;
            held_h_reg     <= '0;
            held_w_reg     <= '0;
            held_b_reg     <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                tare_ms_reg <= cfg_wdata;
            prev_hold_reg  <= prev_hold_next;
            prev_reset_reg <= prev_reset_next;
            prev_tare_reg  <= prev_tare_next;
            offset_reg     <= offset_next;
            tare_flag_reg  <= tare_flag_next;
            tare_start_reg <= tare_start_next;
            hold_flag_reg  <= hold_flag_next;
            held_h_reg     <= held_h_next;
            held_w_reg     <= held_w_next;
            held_b_reg     <= held_b_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    a_hold_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hold_flag_reg) |-> $past(commit_fire))
        else $error("hold set outside a commit");

    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !commit_fire) |=> !m_axis_tvalid)
        else $error("taken word not cleared");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_DIV) |-> (cnt_reg != '0))
        else $error("divider step with no count left");

endmodule
`default_nettype wire

>>> dv/tb_scale_tare_hold_bmi.sv
// Self-checking testbench for the tare/hold/BMI weighing indicator block.
`timescale 1ns / 100ps
module tb_scale_tare_hold_bmi;
    import sthb_pkg::*;

    localparam int STALL_LIMIT  = 2000;   // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES = 32;     // covers the divider path of a word with margin
    localparam int PHASES       = 6;
    localparam int PHASE_WORDS  = 205;

    // one sample tick as driven on the input stream
    typedef struct {
        logic [HEIGHT_W-1:0]     height;
        logic signed [RAW_W-1:0] weight;
        logic                    hold_n;
        logic                    clear_n;
        logic                    tare_n;
        logic [TIME_W-1:0]       now;
    } tick_t;

    // one display word as it leaves the block
    typedef struct {
        logic [HEIGHT_W-1:0]     height;
        logic [NET_W-1:0]        weight;
        logic [BMI_W-1:0]        bmi;
        logic                    holding;
        logic                    tare_lit;
        logic [RAW_W-1:0]        offset;
    } display_t;

    class indicator_board;
        logic [MS_W-1:0]         tare_ms;
        logic                    prev_hold, prev_clear, prev_tare;
        logic signed [RAW_W-1:0] offset;
        logic                    tare_lit;
        logic [TIME_W-1:0]       tare_start;
        logic                    holding;
        logic [HEIGHT_W-1:0]     held_height;
        logic [NET_W-1:0]        held_weight;
        logic [BMI_W-1:0]        held_bmi;
        display_t                expected_displays[$];
        int                      mismatches, checked, ticks;
        int                      tare_presses, hold_latches, bmi_sat, zero_height;

        function new();
            tare_ms     = TARE_MS_RESET;
            prev_hold   = 1'b1;
            prev_clear  = 1'b1;
            prev_tare   = 1'b1;
            offset      = '0;
            tare_lit    = 1'b0;
            tare_start  = '0;
            holding     = 1'b0;
            held_height = '0;
            held_weight = '0;
            held_bmi    = '0;
        endfunction

        function logic [BMI_W-1:0] bmi_centi(logic [HEIGHT_W-1:0] h, logic [NET_W-1:0] w);
            longint unsigned num;
            longint unsigned den;
            longint unsigned q;
            if (h == 0)
                return '0;
            num = w;
            num = num * 100000;
            den = h;
            den = den * h;
            q = num / den;
            return (q > 65535) ? 16'hFFFF : q[BMI_W-1:0];
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task note_tick(tick_t t);
            display_t          e;
            int                diff;
            logic [NET_W-1:0]  net;
            logic [TIME_W-1:0] elapsed;
            ticks++;
            if (t.height == 0)
                zero_height++;
            if (prev_tare && !t.tare_n) begin
                offset     = t.weight;
                tare_lit   = 1'b1;
                tare_start = t.now;
                tare_presses++;
            end
            elapsed = t.now - tare_start;
            if (tare_lit && elapsed >= {16'b0, tare_ms})
                tare_lit = 1'b0;
            diff = int'(t.weight) - int'(offset);
            if (diff < 0)
                net = '0;
            else if (diff > 262143)
                net = '1;
            else
                net = diff[NET_W-1:0];
            // a hold edge while already holding changes nothing
            if (prev_hold && !t.hold_n && !holding) begin
                held_height = t.height;
                held_weight = net;
                held_bmi    = bmi_centi(t.height, net);
                holding     = 1'b1;
                hold_latches++;
            end
            // clear runs after the latch, so both in one tick leaves no hold
            if (prev_clear && !t.clear_n) begin
                holding     = 1'b0;
                held_height = '0;
                held_weight = '0;
                held_bmi    = '0;
            end
            prev_hold  = t.hold_n;
            prev_clear = t.clear_n;
            prev_tare  = t.tare_n;
            if (holding) begin
                e.height = held_height;
                e.weight = held_weight;
                e.bmi    = held_bmi;
            end
            else begin
                e.height = t.height;
                e.weight = net;
                e.bmi    = bmi_centi(t.height, net);
            end
            if (e.bmi == 16'hFFFF)
                bmi_sat++;
            e.holding  = holding;
            e.tare_lit = tare_lit;
            e.offset   = offset;
            expected_displays.push_back(e);
        endtask

        task check_display(logic [OUT_W-1:0] d);
            display_t e;
            if (expected_displays.size() == 0) begin
                report($sformatf("display word %h with nothing expected", d));
                return;
            end
            e = expected_displays.pop_front();
            if (d[11:0] !== e.height)
                report($sformatf("word %0d height got %0d want %0d", checked, d[11:0], e.height));
            if (d[29:12] !== e.weight)
                report($sformatf("word %0d weight got %0d want %0d", checked, d[29:12], e.weight));
            if (d[45:30] !== e.bmi)
                report($sformatf("word %0d bmi got %0d want %0d", checked, d[45:30], e.bmi));
            if (d[46] !== e.holding)
                report($sformatf("word %0d hold got %b want %b", checked, d[46], e.holding));
            if (d[47] !== e.tare_lit)
                report($sformatf("word %0d tare lamp got %b want %b", checked, d[47], e.tare_lit));
            if (d[66:48] !== e.offset)
                report($sformatf("word %0d offset got %h want %h", checked, d[66:48], e.offset));
            checked++;
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             cfg_we;
    logic [MS_W-1:0]  cfg_wdata;

    indicator_board   indicator = new();
    logic             calm;        // no idling on either side while set
    int               cfg_writes;
    logic [TIME_W-1:0] cur_now;
    logic             lvl_hold, lvl_clear, lvl_tare;

    scale_tare_hold_bmi dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function int gap_len();
        if ($urandom_range(0, 19) < 17)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function tick_t mk(int h, int w, int hn, int cn, int tn, logic [TIME_W-1:0] now);
        tick_t t;
        t.height  = h[HEIGHT_W-1:0];
        t.weight  = w[RAW_W-1:0];
        t.hold_n  = hn[0];
        t.clear_n = cn[0];
        t.tare_n  = tn[0];
        t.now     = now;
        return t;
    endfunction

    // mostly realistic button presses and 100 ms ticks, some pure noise
    function tick_t next_tick();
        tick_t t;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 85)
            cur_now = cur_now + $urandom_range(50, 150);
        else if (r < 95)
            cur_now = cur_now + $urandom_range(0, 70000);
        else
            cur_now = $urandom;
        if ($urandom_range(0, 9) == 0) begin
            lvl_hold  = ($urandom_range(0, 1) == 1);
            lvl_clear = ($urandom_range(0, 1) == 1);
            lvl_tare  = ($urandom_range(0, 1) == 1);
        end
        else begin
            lvl_hold  = lvl_hold  ? ($urandom_range(0, 9) != 0)  : ($urandom_range(0, 1) == 1);
            lvl_clear = lvl_clear ? ($urandom_range(0, 24) != 0) : ($urandom_range(0, 1) == 1);
            lvl_tare  = lvl_tare  ? ($urandom_range(0, 11) != 0) : ($urandom_range(0, 1) == 1);
        end
        r = $urandom_range(0, 9);
        if (r < 7)
            t.height = HEIGHT_W'($urandom_range(1000, 2100));
        else if (r == 7)
            t.height = '0;
        else if (r == 8)
            t.height = HEIGHT_W'($urandom_range(1, 200));
        else
            t.height = HEIGHT_W'($urandom);
        r = $urandom_range(0, 19);
        if (r < 12)
            t.weight = RAW_W'($urandom_range(20000, 150000));
        else if (r < 15)
            t.weight = RAW_W'(int'($urandom_range(0, 4000)) - 2000);
        else
            t.weight = RAW_W'($urandom);
        t.hold_n  = lvl_hold;
        t.clear_n = lvl_clear;
        t.tare_n  = lvl_tare;
        t.now     = cur_now;
        return t;
    endfunction

    // called and returns at a falling edge; tvalid stays up for a following word
    task send_tick(tick_t t);
        if (!calm && $urandom_range(0, 2) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap_len()) @(negedge clk);
        end
        s_axis_tdata  = {6'b0, t.now, t.tare_n, t.clear_n, t.hold_n, t.weight, t.height};
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        indicator.note_tick(t);
        @(negedge clk);
    endtask

    task drain();
        while (indicator.expected_displays.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task write_tare_ms(logic [MS_W-1:0] ms);
        s_axis_tvalid = 1'b0;
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = ms;
        @(negedge clk);
        cfg_we    = 1'b0;
        indicator.tare_ms = ms;
        cfg_writes++;
    endtask

    // output side: random stalls, none while calm
    initial
    begin
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                stall--;
            end
            else begin
                m_axis_tready = 1'b1;
                if (!calm && $urandom_range(0, 4) == 0)
                    stall = gap_len();
            end
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            indicator.check_display(m_axis_tdata);

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        logic [MS_W-1:0] phase_ms [PHASES];
        int              p;
        int              i;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        calm          = 1'b0;
        cfg_writes    = 0;
        cur_now       = 32'd2000;
        lvl_hold      = 1'b1;
        lvl_clear     = 1'b1;
        lvl_tare      = 1'b1;
        phase_ms[0] = TARE_MS_RESET;
        phase_ms[1] = 16'd0;
        phase_ms[2] = 16'hFFFF;
        phase_ms[3] = 16'd1;
        phase_ms[4] = MS_W'($urandom_range(100, 5000));
        phase_ms[5] = MS_W'($urandom);
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: field extremes, tare, hold and clear corners, time wrap
        write_tare_ms(TARE_MS_RESET);
        send_tick(mk(1750, 70000, 1, 1, 1, 32'd0));
        send_tick(mk(0, 70000, 1, 1, 1, 32'd100));          // no height, no BMI
        send_tick(mk(4095, 262143, 1, 1, 1, 32'd200));
        send_tick(mk(1, 262143, 1, 1, 1, 32'd300));         // BMI saturates
        send_tick(mk(1700, -262144, 1, 1, 1, 32'd400));     // negative net clamps
        send_tick(mk(1700, -262144, 1, 1, 0, 32'd500));     // tare at most negative
        send_tick(mk(1700, 262143, 1, 1, 1, 32'd600));      // net saturates
        send_tick(mk(1700, 0, 1, 1, 1, 32'd1500));          // lamp times out
        send_tick(mk(1700, 0, 1, 1, 0, 32'd1600));
        send_tick(mk(1700, 5000, 1, 1, 0, 32'd1700));       // tare still down, no edge
        send_tick(mk(1800, 80000, 0, 1, 1, 32'd1800));      // hold latches
        send_tick(mk(1600, 90000, 0, 1, 1, 32'd1900));
        send_tick(mk(1000, 10000, 1, 1, 1, 32'd2000));
        send_tick(mk(1200, 20000, 0, 1, 1, 32'd2100));      // hold while held
        send_tick(mk(1300, 30000, 1, 0, 1, 32'd2200));      // clear drops hold
        send_tick(mk(1400, 40000, 1, 1, 1, 32'd2300));
        send_tick(mk(1500, 50000, 0, 0, 1, 32'd2400));      // hold and clear together
        send_tick(mk(1500, 50000, 1, 1, 1, 32'd2500));
        send_tick(mk(1650, 123456, 1, 1, 0, 32'hFFFF_FFFF)); // tare just before wrap
        send_tick(mk(1650, 150000, 1, 1, 1, 32'h0000_0100));
        send_tick(mk(1650, 150000, 1, 1, 1, 32'h0000_0400));
        write_tare_ms(16'd0);
        send_tick(mk(1700, 60000, 1, 1, 0, 32'd3000));      // lamp off on the same tick
        send_tick(mk(1700, 75000, 1, 1, 1, 32'd3100));

        for (p = 0; p < PHASES; p++) begin
            write_tare_ms(phase_ms[p]);
            for (i = 0; i < PHASE_WORDS; i++) begin
                if (i % 40 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                send_tick(next_tick());
            end
        end

        s_axis_tvalid = 1'b0;
        calm = 1'b0;
        drain();
        $display("Sent %0d sample words, checked %0d display words, %0d lamp time settings.",
                 indicator.ticks, indicator.checked, cfg_writes);
        $display("Saw %0d tare presses, %0d hold latches, %0d saturated BMI, %0d zero heights.",
                 indicator.tare_presses, indicator.hold_latches, indicator.bmi_sat,
                 indicator.zero_height);
        if (indicator.mismatches == 0 && indicator.expected_displays.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> scale_tare_hold_bmi.f
src/sthb_pkg.sv
src/sthb_seq.sv
src/scale_tare_hold_bmi.sv
dv/tb_scale_tare_hold_bmi.sv
